// File: rtl/afr_pkg.sv
// Shared types, constants and the hex digit decoder for the addressed frame receiver.
package afr_pkg;

    localparam logic [7:0] START_BYTE = 8'hFF;

    // Register map (paddr holds the register index)
    localparam logic [1:0] REG_OWN_ADDRESS = 2'd0;
    localparam logic [7:0] OWN_ADDRESS_RESET = 8'h01;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic in_ready;
        logic load_src;
        logic load_len;
        logic store_byte;
        logic start_echo;
        logic emit;
    } afr_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic start_hit;
        logic addr_match;
        logic len_ok;
        logic len_dec_zero;
        logic exp_zero;
        logic data_done;
        logic echo_last;
        logic out_free;
    } afr_sts_t;

    // ASCII hex digit decode: {valid, value}
    function automatic logic [4:0] afr_hex(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        return r;
    endfunction

endpackage

// File: rtl/addressed_frame_receiver.sv
// Top level of the addressed frame receiver: config register, controller and datapath.
//
// Channel   Direction  Handshake                   Contents
// s_axis    in         tvalid/tready               tdata[7:0] = rx_byte
// m_axis    out        tvalid/tready               tdata = payload_byte, source_address;
//                                                  tlast = last_byte
// apb       in         psel/penable/pwrite/pready  0x0: own_address (reset 0x01)
//
// Header, length, data and closing bytes are taken one per cycle.
// After the closing byte the controller echoes one stored byte per cycle through
// the output register while the output is not stalled; no input is taken while echoing.
// Reset returns the parser to hunting for a start byte; the store is not cleared.
module addressed_frame_receiver
    import afr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Echoed payload
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] source_address
    output logic        m_axis_tlast,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] own_address_reg;
    afr_cmd_t   cmd;
    afr_sts_t   sts;
    logic       cfg_write;
    logic [7:0] out_payload;
    logic [7:0] out_source;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == REG_OWN_ADDRESS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            own_address_reg <= OWN_ADDRESS_RESET;
        else if (cfg_write)
            own_address_reg <= pwdata[7:0];
    end

    always_comb
    begin
        unique case (paddr)
            REG_OWN_ADDRESS: prdata = {24'd0, own_address_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // Controller
    afr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    afr_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (s_axis_tdata),
        .own_address (own_address_reg),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_payload (out_payload),
        .out_source  (out_source),
        .out_last    (m_axis_tlast)
    );

    assign s_axis_tready = cmd.in_ready;
    assign m_axis_tdata  = {out_source, out_payload};

    // A byte is only stored on an accepted request
    a_store_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_byte |-> (s_axis_tvalid && s_axis_tready))
        else $error("payload byte stored without an accepted request");

    // Echo never overwrites a result that has not been taken
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("echo overwrote a pending result");

    // Input is held off while echoing
    a_no_input_in_echo: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !s_axis_tready)
        else $error("input accepted during echo");

    // The last echoed byte carries tlast and reopens the input
    a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.echo_last) |=> (s_axis_tready && m_axis_tvalid && m_axis_tlast))
        else $error("frame end not marked or input not reopened");

endmodule

// File: rtl/afr_ctrl.sv
// Frame parsing and echo controller for the addressed frame receiver.
module afr_ctrl
    import afr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  afr_sts_t sts,
    output afr_cmd_t cmd
);

    localparam logic [2:0] ST_HUNT  = 3'd0;
    localparam logic [2:0] ST_DEST  = 3'd1;
    localparam logic [2:0] ST_SRC   = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_DATA  = 3'd4;
    localparam logic [2:0] ST_CLOSE = 3'd5;
    localparam logic [2:0] ST_ECHO  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign accept = in_valid && (state_reg != ST_ECHO);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.in_ready = (state_reg != ST_ECHO);
        unique case (state_reg)
            ST_HUNT:
            begin
                if (accept && sts.start_hit)
                    state_next = ST_DEST;
            end
            ST_DEST:
            begin
                if (accept)
                    state_next = sts.addr_match ? ST_SRC : ST_HUNT;
            end
            ST_SRC:
            begin
                if (accept)
                begin
                    cmd.load_src = 1'b1;
                    state_next   = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (accept)
                begin
                    if (!sts.len_ok)
                        state_next = ST_HUNT;
                    else
                    begin
                        cmd.load_len = 1'b1;
                        state_next   = sts.len_dec_zero ? ST_CLOSE : ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (accept)
                begin
                    cmd.store_byte = 1'b1;
                    if (sts.data_done)
                        state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                // Closing byte value is not checked
                if (accept)
                begin
                    if (sts.exp_zero)
                        state_next = ST_HUNT;
                    else
                    begin
                        cmd.start_echo = 1'b1;
                        state_next     = ST_ECHO;
                    end
                end
            end
            ST_ECHO:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.echo_last)
                        state_next = ST_HUNT;
                end
            end
            default:
            begin
                if (accept)
                    state_next = ST_HUNT;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_HUNT;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/afr_dp.sv
// Datapath of the addressed frame receiver: field checks, payload store, output register.
module afr_dp
    import afr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  own_address,
    input  afr_cmd_t    cmd,
    output afr_sts_t    sts,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [7:0]  out_payload,
    output logic [7:0]  out_source,
    output logic        out_last
);

    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [4:0]    hex;
    logic [CW-1:0] dec_len;
    logic [7:0]    src_reg;
    logic [CW-1:0] exp_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] idx_reg;
    logic [7:0]    store_reg [MAX_PAYLOAD];
    logic          out_valid_reg;
    logic [7:0]    out_payload_reg;
    logic [7:0]    out_source_reg;
    logic          out_last_reg;

    // Field checks
    assign hex     = afr_hex(rx_byte);
    assign dec_len = CW'(hex[3:0]);

    always_comb
    begin
        sts              = '0;
        sts.start_hit    = (rx_byte == START_BYTE);
        sts.addr_match   = (rx_byte == own_address);
        sts.len_ok       = hex[4] && ({1'b0, hex[3:0]} <= 5'(MAX_PAYLOAD));
        sts.len_dec_zero = (hex[3:0] == 4'd0);
        sts.exp_zero     = (exp_reg == '0);
        sts.data_done    = (({1'b0, cnt_reg} + (CW+1)'(1)) >= {1'b0, exp_reg});
        sts.echo_last    = (({1'b0, idx_reg} + (CW+1)'(1)) == {1'b0, exp_reg});
        sts.out_free     = !out_valid_reg || out_ready;
    end

    // Frame counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg <= '0;
            cnt_reg <= '0;
            idx_reg <= '0;
            src_reg <= '0;
        end
        else
        begin
            if (cmd.load_src)
                src_reg <= rx_byte;
            if (cmd.load_len)
            begin
                exp_reg <= dec_len;
                cnt_reg <= '0;
            end
            else if (cmd.store_byte)
                cnt_reg <= cnt_reg + CW'(1);
            if (cmd.start_echo)
                idx_reg <= '0;
            else if (cmd.emit)
                idx_reg <= idx_reg + CW'(1);
        end
    end

    // Payload store, one entry written per data byte
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
            store_reg[cnt_reg[IW-1:0]] <= rx_byte;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_payload_reg <= store_reg[idx_reg[IW-1:0]];
            out_source_reg  <= src_reg;
            out_last_reg    <= sts.echo_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_payload = out_payload_reg;
    assign out_source  = out_source_reg;
    assign out_last    = out_last_reg;

endmodule

// File: tb/addressed_frame_receiver_test.sv
// Self-checking testbench for the addressed frame receiver: random frames, stalls, address changes.
`timescale 1ns / 100ps

module addressed_frame_receiver_test
    import afr_pkg::*;
();

    localparam int PAYLOAD_CAP   = 8;
    localparam int CLK_PERIOD    = 20;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_BYTES   = 33;

    typedef enum logic [2:0] {
        RX_HUNT,
        RX_DEST,
        RX_SRC,
        RX_LEN,
        RX_DATA,
        RX_CLOSE
    } rx_phase_e;

    typedef struct packed {
        logic [7:0] payload;
        logic [7:0] source;
        logic       last;
    } echo_t;

    // Frame parser mirror plus the queue of echoes still owed by the block
    class frame_echo_model;
        logic [7:0] own_address;
        rx_phase_e  phase;
        logic [3:0] byte_count;
        logic [3:0] frame_length;
        logic [7:0] source;
        logic [7:0] store [PAYLOAD_CAP];
        echo_t      echo_due [$];
        int         mismatches;
        int         busy_bytes;

        function new();
            own_address  = OWN_ADDRESS_RESET;
            phase        = RX_HUNT;
            byte_count   = '0;
            frame_length = '0;
            source       = '0;
            mismatches   = 0;
            busy_bytes   = 0;
        endfunction

        function int pending();
            return echo_due.size();
        endfunction

        function void write_register(logic [1:0] addr, logic [31:0] data);
            if (addr == REG_OWN_ADDRESS)
                own_address = data[7:0];
        endfunction

        // ASCII hex digit value, -1 when the byte is not a digit
        function int digit_value(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c) - int'("0");
            if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
            if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
            return -1;
        endfunction

        // Advance the parser by one accepted request
        function void note_rx_byte(logic [7:0] b);
            int    len;
            echo_t e;
            if (phase != RX_HUNT || b == START_BYTE)
                busy_bytes++;
            case (phase)
                RX_HUNT:
                    if (b == START_BYTE) phase = RX_DEST;
                RX_DEST:
                    phase = (b == own_address) ? RX_SRC : RX_HUNT;
                RX_SRC:
                    begin
                        source = b;
                        phase  = RX_LEN;
                    end
                RX_LEN:
                    begin
                        len = digit_value(b);
                        if (len < 0 || len > PAYLOAD_CAP) begin
                            phase = RX_HUNT;
                        end
                        else begin
                            frame_length = len[3:0];
                            byte_count   = '0;
                            phase        = (len == 0) ? RX_CLOSE : RX_DATA;
                        end
                    end
                RX_DATA:
                    begin
                        if (byte_count < PAYLOAD_CAP)
                            store[byte_count[2:0]] = b;
                        byte_count = byte_count + 4'd1;
                        if (byte_count >= frame_length) phase = RX_CLOSE;
                    end
                RX_CLOSE:
                    begin
                        // closing byte value is don't-care
                        for (int k = 0; k < frame_length && k < PAYLOAD_CAP; k++) begin
                            e.payload = store[k];
                            e.source  = source;
                            e.last    = (k + 1 == frame_length);
                            echo_due.push_back(e);
                        end
                        phase = RX_HUNT;
                    end
                default:
                    phase = RX_HUNT;
            endcase
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        // Compare one accepted echo with the oldest one owed
        task check_echo(logic [7:0] payload, logic [7:0] src, logic last);
            echo_t e;
            if (echo_due.size() == 0) begin
                report_mismatch($sformatf("unexpected echo payload %02h source %02h last %0b",
                                          payload, src, last));
                return;
            end
            e = echo_due.pop_front();
            if (payload !== e.payload)
                report_mismatch($sformatf("payload %02h, want %02h", payload, e.payload));
            if (src !== e.source)
                report_mismatch($sformatf("source %02h, want %02h", src, e.source));
            if (last !== e.last)
                report_mismatch($sformatf("last %0b, want %0b", last, e.last));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] payload_byte, [15:8] source_address
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = 2'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    frame_echo_model echoes = new();
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  full_speed = 1'b0;

    addressed_frame_receiver #(
        .MAX_PAYLOAD (PAYLOAD_CAP)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Echo checking and inactivity count
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            echoes.check_echo(m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast);
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
            (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("addressed_frame_receiver regression: fail");
        $finish;
    end

    // Receiver backpressure: mostly short stalls, a few long ones, none at full speed
    always @(negedge clk)
    begin
        int r;
        if (full_speed) begin
            m_axis_tready <= 1'b1;
            stall_left = 0;
        end
        else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                m_axis_tready <= 1'b1;
            end
            else begin
                m_axis_tready <= 1'b0;
                stall_left = (r < 92) ? $urandom_range(0, 3) : $urandom_range(10, 40);
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if (full_speed) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one byte and wait for it to be taken
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        echoes.note_rx_byte(b);
    endtask

    // Drop valid and hold off until every owed echo has come out
    task automatic wait_for_echoes();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (echoes.pending() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        wait_for_echoes();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] addr, logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        echoes.write_register(addr, data);
        @(negedge clk);
        // read back the register just written
        if (addr == REG_OWN_ADDRESS && prdata !== {24'd0, data[7:0]})
            echoes.report_mismatch($sformatf("readback %08h, want %08h",
                                             prdata, {24'd0, data[7:0]}));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One frame: mostly well formed, sometimes broken at a random point
    task automatic random_frame();
        int         n;
        int         r;
        logic [7:0] dest;
        logic [7:0] len_char;
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 254)));
        end
        send_byte(START_BYTE);
        dest = ($urandom_range(0, 9) == 0) ? 8'($urandom) : echoes.own_address;
        send_byte(dest);
        if (dest != echoes.own_address) return;
        send_byte(8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 85) begin
            n = $urandom_range(0, PAYLOAD_CAP);
            len_char = 8'("0") + 8'(n);
        end
        else begin
            // bad length: digit above capacity, hex letter or plain noise
            case ($urandom_range(0, 3))
                0: len_char = "9";
                1: len_char = 8'("A") + 8'($urandom_range(0, 5));
                2: len_char = 8'("a") + 8'($urandom_range(0, 5));
                default: len_char = 8'($urandom);
            endcase
            send_byte(len_char);
            return;
        end
        send_byte(len_char);
        if (n > 0 && $urandom_range(0, 19) == 0)
            n = $urandom_range(0, n - 1);   // truncated frame
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom));
        send_byte(8'($urandom));
    endtask

    initial
    begin
        logic [7:0] directed [] = '{
            // noise while hunting, start byte taken as a wrong address, stray own address
            8'h00, 8'hFF, 8'hFF, 8'h01,
            // zero-length frame, start byte as source
            8'hFF, 8'h01, 8'hFF, "0", 8'hAA,
            // length above capacity aborts
            8'hFF, 8'h01, 8'h5A, "9",
            // full frame with extreme payload bytes
            8'hFF, 8'h01, 8'h00, "8", 8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE,
            8'h55, 8'hAA, 8'h00
        };
        logic [7:0] addresses [] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00, OWN_ADDRESS_RESET};
        int target;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_byte(directed[i]);
        settle();

        addresses[4] = 8'($urandom);
        foreach (addresses[p]) begin
            apb_write(REG_OWN_ADDRESS, {24'($urandom), addresses[p]});
            full_speed = (p == 2);
            target = echoes.busy_bytes + PHASE_BYTES;
            while (echoes.busy_bytes < target) begin
                if ($urandom_range(0, 24) == 0)
                    wait_for_echoes();
                random_frame();
            end
            settle();
        end

        if (echoes.pending() != 0)
            echoes.report_mismatch($sformatf("%0d echoes never arrived", echoes.pending()));
        if (echoes.mismatches == 0)
            $display("addressed_frame_receiver regression: pass");
        else
            $display("addressed_frame_receiver regression: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/afr_pkg.sv
rtl/afr_ctrl.sv
rtl/afr_dp.sv
rtl/addressed_frame_receiver.sv
tb/addressed_frame_receiver_test.sv
